/* hdl/djmc_pkg.sv */
package djmc_pkg;

  localparam int unsigned CFG_W       = 15;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 1'd1;

  localparam logic [CFG_W-1:0] TICK_PERIOD_RESET = 15'd1;
  localparam logic [CFG_W-1:0] THRESHOLD_RESET   = 15'd40;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_UP      = 3'd1,
    ST_DOWN    = 3'd2,
    ST_DB_UP   = 3'd3,
    ST_DB_DOWN = 3'd4
  } state_t;

  typedef struct packed {
    logic [2:0] motor_state;
    logic       running;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] tick_period_ms;
    logic [CFG_W-1:0] debounce_threshold_ms;
  } cfg_t;

endpackage

/* hdl/djmc_ifs.sv */
interface djmc_button_if;
  logic valid;
  logic ready;
  logic up_pressed;
  logic down_pressed;

  modport source (output valid, output up_pressed, output down_pressed, input ready);
  modport sink (input valid, input up_pressed, input down_pressed, output ready);
endinterface

interface djmc_status_if;
  logic       valid;
  logic       ready;
  logic [2:0] motor_state;
  logic       running;

  modport source (output valid, output motor_state, output running, input ready);
  modport sink (input valid, input motor_state, input running, output ready);
endinterface

/* hdl/djmc_cfg.sv */
module djmc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [djmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [djmc_pkg::CFG_W-1:0]       cfg_data,
  output djmc_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period_ms        <= djmc_pkg::TICK_PERIOD_RESET;
      cfg.debounce_threshold_ms <= djmc_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        djmc_pkg::REG_TICK_PERIOD: cfg.tick_period_ms        <= cfg_data;
        djmc_pkg::REG_THRESHOLD:   cfg.debounce_threshold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/djmc_core.sv */
module djmc_core #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                up,
  input  logic                down,
  input  djmc_pkg::cfg_t      cfg,
  output djmc_pkg::result_t   result
);

  localparam int unsigned SUM_W =
    ((TIME_WIDTH > djmc_pkg::CFG_W) ? TIME_WIDTH : djmc_pkg::CFG_W) + 1;

  djmc_pkg::state_t        state, state_next;
  logic                    up_tent, up_tent_next;
  logic                    down_tent, down_tent_next;
  logic [TIME_WIDTH-1:0]   elapsed, elapsed_next;

  logic                    decide;
  logic [SUM_W-1:0]        sum;
  logic [TIME_WIDTH-1:0]   elapsed_add;

  // Decision clears the accumulator before this tick's period is added.
  assign decide = SUM_W'(elapsed) >= SUM_W'(cfg.debounce_threshold_ms);
  assign sum    = (decide ? '0 : SUM_W'(elapsed)) + SUM_W'(cfg.tick_period_ms);
  assign elapsed_add = ((sum >> TIME_WIDTH) != '0) ? '1 : sum[TIME_WIDTH-1:0];

  always_comb begin
    state_next     = state;
    up_tent_next   = up_tent;
    down_tent_next = down_tent;
    elapsed_next   = elapsed;
    unique case (state)
      djmc_pkg::ST_IDLE: begin
        if (down) begin
          down_tent_next = 1'b1;
          state_next     = djmc_pkg::ST_DB_DOWN;
        end else if (up) begin
          up_tent_next = 1'b1;
          state_next   = djmc_pkg::ST_DB_UP;
        end
      end
      djmc_pkg::ST_UP: begin
        if (!up) begin
          up_tent_next = 1'b0;
          state_next   = djmc_pkg::ST_DB_UP;
        end
      end
      djmc_pkg::ST_DOWN: begin
        if (!down) begin
          down_tent_next = 1'b0;
          state_next     = djmc_pkg::ST_DB_DOWN;
        end
      end
      djmc_pkg::ST_DB_UP: begin
        elapsed_next = elapsed_add;
        if (decide) begin
          up_tent_next = up;
          state_next   = up ? djmc_pkg::ST_UP : djmc_pkg::ST_IDLE;
        end
      end
      djmc_pkg::ST_DB_DOWN: begin
        elapsed_next = elapsed_add;
        if (decide) begin
          down_tent_next = down;
          state_next     = down ? djmc_pkg::ST_DOWN : djmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next     = djmc_pkg::ST_IDLE;
        up_tent_next   = 1'b0;
        down_tent_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.motor_state = state_next;
    result.running     = (state_next == djmc_pkg::ST_UP) ||
                         (state_next == djmc_pkg::ST_DOWN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= djmc_pkg::ST_IDLE;
      up_tent   <= 1'b0;
      down_tent <= 1'b0;
      elapsed   <= '0;
    end else if (step) begin
      state     <= state_next;
      up_tent   <= up_tent_next;
      down_tent <= down_tent_next;
      elapsed   <= elapsed_next;
    end
  end

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(state) && $stable(elapsed) && $stable(up_tent) && $stable(down_tent))
    else $error("state changed without an item");

  a_idle_stays_idle: assert property (@(posedge clk) disable iff (rst)
    step && state == djmc_pkg::ST_IDLE && !up && !down |=> state == djmc_pkg::ST_IDLE)
    else $error("idle left with no button pressed");

  a_up_held: assert property (@(posedge clk) disable iff (rst)
    step && state == djmc_pkg::ST_UP && up |=> state == djmc_pkg::ST_UP)
    else $error("going up left while up held");

  a_moving_keeps_time: assert property (@(posedge clk) disable iff (rst)
    step && (state == djmc_pkg::ST_UP || state == djmc_pkg::ST_DOWN) |=> $stable(elapsed))
    else $error("accumulator moved outside debounce");

endmodule

/* hdl/debounced_jog_motor_control.sv */
// Debounced jog control for a motor with an up and a down push button.
// button: one item per sampling tick carrying up_pressed and down_pressed
//   (1 = pressed). Accepted when valid and ready are both high.
// status: one item per accepted button item, in order, with the new
//   motor_state (0 idle, 1 up, 2 down, 3 debounce up, 4 debounce down)
//   and running (1 while going up or down).
// cfg_we/cfg_index/cfg_data: register 0 is tick_period_ms, register 1 is
//   debounce_threshold_ms, both 15 bits; write only while no item is in flight.
// Path: an accepted button item goes into the input register, then the state
//   update writes the result register, which drives status.
// Throughput: one item per cycle while status is not stalled; the state
//   update is a single compare and a saturating add, fed back to itself.
// Reset (rst, synchronous): state idle, tentative flags and accumulator
//   cleared, registers back to 1 ms and 40 ms, both stages empty.
// When status is stalled the result register holds; the input register
//   takes one more item, then button.ready drops until status drains.
module debounced_jog_motor_control #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [djmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [djmc_pkg::CFG_W-1:0]       cfg_data,
  djmc_button_if.sink                      button,
  djmc_status_if.source                    status
);

  djmc_pkg::cfg_t    cfg;
  djmc_pkg::result_t result;

  logic s1_valid;
  logic s1_up;
  logic s1_down;
  logic advance;
  logic out_valid;
  djmc_pkg::result_t out_data;

  assign advance      = s1_valid && (!out_valid || status.ready);
  assign button.ready = !s1_valid || advance;

  djmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  djmc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .up     (s1_up),
    .down   (s1_down),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (button.ready) begin
      s1_valid <= button.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (button.valid && button.ready) begin
      s1_up   <= button.up_pressed;
      s1_down <= button.down_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign status.valid       = out_valid;
  assign status.motor_state = out_data.motor_state;
  assign status.running     = out_data.running;

  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input item dropped while stalled");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item has no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status.ready |-> !advance)
    else $error("result overwritten while stalled");

endmodule

/* verif/djmc_status_checker.sv */
module djmc_status_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [djmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [djmc_pkg::CFG_W-1:0]       cfg_data,
  djmc_button_if                           button,
  djmc_status_if                           status,
  output int unsigned                      errors,
  output int unsigned                      outstanding
);

  localparam int unsigned TIME_W = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic [djmc_pkg::CFG_W-1:0] tick_ms;
  logic [djmc_pkg::CFG_W-1:0] threshold_ms;
  djmc_pkg::state_t           jog_state;
  logic                       up_held;
  logic                       down_held;
  logic [TIME_W-1:0]          elapsed;
  djmc_pkg::result_t          status_expected[$];
  int unsigned                reported;

  // One debounce tick: decide once the accumulator reaches the threshold, then add the period.
  function automatic djmc_pkg::state_t debounce_tick(input logic level, inout logic held,
                                                     input djmc_pkg::state_t moving);
    djmc_pkg::state_t nxt;
    logic [TIME_W:0]  sum;
    nxt = jog_state;
    if (elapsed >= {1'b0, threshold_ms}) begin
      nxt  = level ? moving : djmc_pkg::ST_IDLE;
      held = level;
      elapsed = '0;
    end
    sum = {1'b0, elapsed} + {2'b00, tick_ms};
    elapsed = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    return nxt;
  endfunction

  function automatic djmc_pkg::result_t next_status(input logic up, input logic down);
    djmc_pkg::result_t r;
    case (jog_state)
      djmc_pkg::ST_IDLE: begin
        if (down) begin
          down_held = 1'b1;
          jog_state = djmc_pkg::ST_DB_DOWN;
        end else if (up) begin
          up_held   = 1'b1;
          jog_state = djmc_pkg::ST_DB_UP;
        end
      end
      djmc_pkg::ST_UP: begin
        if (!up) begin
          up_held   = 1'b0;
          jog_state = djmc_pkg::ST_DB_UP;
        end
      end
      djmc_pkg::ST_DOWN: begin
        if (!down) begin
          down_held = 1'b0;
          jog_state = djmc_pkg::ST_DB_DOWN;
        end
      end
      djmc_pkg::ST_DB_UP:   jog_state = debounce_tick(up, up_held, djmc_pkg::ST_UP);
      djmc_pkg::ST_DB_DOWN: jog_state = debounce_tick(down, down_held, djmc_pkg::ST_DOWN);
      default: begin
        jog_state = djmc_pkg::ST_IDLE;
        up_held   = 1'b0;
        down_held = 1'b0;
      end
    endcase
    r.motor_state = jog_state;
    r.running     = (jog_state == djmc_pkg::ST_UP) || (jog_state == djmc_pkg::ST_DOWN);
    return r;
  endfunction

  always @(posedge clk) begin
    djmc_pkg::result_t got;
    djmc_pkg::result_t want;
    if (rst) begin
      tick_ms      = djmc_pkg::TICK_PERIOD_RESET;
      threshold_ms = djmc_pkg::THRESHOLD_RESET;
      jog_state    = djmc_pkg::ST_IDLE;
      up_held      = 1'b0;
      down_held    = 1'b0;
      elapsed      = '0;
      errors       = 0;
      reported     = 0;
      status_expected.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == djmc_pkg::REG_TICK_PERIOD) tick_ms = cfg_data;
        else if (cfg_index == djmc_pkg::REG_THRESHOLD) threshold_ms = cfg_data;
      end
      if (button.valid && button.ready)
        status_expected.push_back(next_status(button.up_pressed, button.down_pressed));
      if (status.valid && status.ready) begin
        got.motor_state = status.motor_state;
        got.running     = status.running;
        if (status_expected.size() == 0) begin
          errors++;
          if (reported < 10) begin
            $display("unexpected status item: state %0d running %0b",
                     got.motor_state, got.running);
            reported++;
          end
        end else begin
          want = status_expected.pop_front();
          if (got.motor_state != want.motor_state || got.running != want.running) begin
            errors++;
            if (reported < 10) begin
              $display("status mismatch: state exp %0d got %0d, running exp %0b got %0b",
                       want.motor_state, got.motor_state, want.running, got.running);
              reported++;
            end
          end
        end
      end
    end
    outstanding = status_expected.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;

  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned HOLD_OFF_AT  = 400;
  localparam int unsigned HOLD_OFF_LEN = 120;

  // Levels are {up, down}.
  localparam logic [1:0] OPENING [0:21] = '{
    2'b00, 2'b11, 2'b01, 2'b01, 2'b01, 2'b01, 2'b00, 2'b01, 2'b01, 2'b00, 2'b00,
    2'b00, 2'b10, 2'b10, 2'b00, 2'b10, 2'b10, 2'b10, 2'b11, 2'b01, 2'b00, 2'b00
  };
  localparam logic [djmc_pkg::CFG_W-1:0] PHASE_TICK [0:PHASES-1] = '{
    15'd1, 15'd0, 15'd32767, 15'd1, 15'd3, 15'd7, 15'd32767, 15'd2
  };
  localparam logic [djmc_pkg::CFG_W-1:0] PHASE_THRESHOLD [0:PHASES-1] = '{
    15'd40, 15'd0, 15'd32767, 15'd0, 15'd9, 15'd20, 15'd0, 15'd32767
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [djmc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [djmc_pkg::CFG_W-1:0]       cfg_data = '0;
  int unsigned                      errors;
  int unsigned                      outstanding;
  int unsigned                      quiet = 0;

  djmc_button_if button_ch ();
  djmc_status_if status_ch ();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  debounced_jog_motor_control dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .button    (button_ch),
    .status    (status_ch)
  );

  djmc_status_checker status_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .button      (button_ch),
    .status      (status_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  task automatic offer_tick(input logic up, input logic down, input bit calm);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      button_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    button_ch.valid        <= 1'b1;
    button_ch.up_pressed   <= up;
    button_ch.down_pressed <= down;
    do @(posedge clk); while (!button_ch.ready);
  endtask

  // Hold the button side until every status item is back and the pipeline is empty.
  task automatic drain_status();
    @(negedge clk);
    button_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_timing(input logic [djmc_pkg::CFG_W-1:0] tick,
                             input logic [djmc_pkg::CFG_W-1:0] threshold);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= djmc_pkg::REG_TICK_PERIOD;
    cfg_data  <= tick;
    @(negedge clk);
    cfg_index <= djmc_pkg::REG_THRESHOLD;
    cfg_data  <= threshold;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic        up_level;
    logic        down_level;
    bit          calm;
    int unsigned flip_span;
    button_ch.valid        = 1'b0;
    button_ch.up_pressed   = 1'b0;
    button_ch.down_pressed = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_timing(15'd3, 15'd6);
    foreach (OPENING[i]) offer_tick(OPENING[i][1], OPENING[i][0], 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain_status();
      load_timing(PHASE_TICK[p], PHASE_THRESHOLD[p]);
      calm      = ($urandom_range(0, 3) == 0);
      flip_span = 1 << $urandom_range(1, 5);
      up_level   = 1'b0;
      down_level = 1'b0;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: a one-tick glitch on both buttons
          offer_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), calm);
        end else begin
          if ($urandom_range(0, flip_span - 1) == 0) up_level = !up_level;
          if ($urandom_range(0, flip_span - 1) == 0) down_level = !down_level;
          offer_tick(up_level, down_level, calm);
        end
      end
    end

    drain_status();
    repeat (8) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned taken;
    int unsigned gap;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    status_ch.ready = 1'b0;
    forever begin
      if (taken % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 6);
      // stall long enough for the block to fill and drop button ready
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_LEN;
      repeat (gap) begin
        @(negedge clk);
        status_ch.ready <= 1'b0;
        @(posedge clk);
      end
      @(negedge clk);
      status_ch.ready <= 1'b1;
      do @(posedge clk); while (!status_ch.valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (button_ch.valid && button_ch.ready) ||
        (status_ch.valid && status_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

/* files.f */
hdl/djmc_pkg.sv
hdl/djmc_ifs.sv
hdl/djmc_cfg.sv
hdl/djmc_core.sv
hdl/debounced_jog_motor_control.sv
verif/djmc_status_checker.sv
verif/tb_top.sv
